@@ design/indexed_bmp_stream_decoder_defines.svh @@
// Assertion macros shared by the decoder modules.
// Depends on nothing; included by files that carry assertions.
`ifndef INDEXED_BMP_STREAM_DECODER_DEFINES_SVH
`define INDEXED_BMP_STREAM_DECODER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define IBSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define IBSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

@@ design/ibsd_pkg.sv @@
// Types and constants of the indexed BMP stream decoder.
// Depends on nothing; used by every design module.
package ibsd_pkg;
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_COLOR  = 3'd1;
	localparam logic [2:0] KIND_PIXEL  = 3'd2;
	localparam logic [2:0] KIND_ERROR  = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;

	localparam logic [2:0] ERR_SIGNATURE = 3'd0;
	localparam logic [2:0] ERR_FORMAT    = 3'd1;
	localparam logic [2:0] ERR_PALETTE   = 3'd2;
	localparam logic [2:0] ERR_OFFSET    = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

	localparam int HEADER_BYTES = 54;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_HEADER   = 7'b0000001,
		PH_SKIP_PAL = 7'b0000010,
		PH_PALETTE  = 7'b0000100,
		PH_SKIP_PIX = 7'b0001000,
		PH_PIXELS   = 7'b0010000,
		PH_DONE     = 7'b0100000,
		PH_ERROR    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [10:0] image_width;
		logic [10:0] image_height;
		logic [8:0]  color_count;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_item_t;

	// Classified byte handed from front to back
	typedef struct packed {
		logic       single;    // one result from front, no pixel run
		out_item_t  res;       // that result (also the message when single)
		logic       pix;       // unpack a pixel byte
		logic [7:0] pbyte;
		logic [1:0] depth;     // 0:1bpp 1:4bpp 2:8bpp
		logic [10:0] x0;       // first x of this byte
		logic [10:0] width;
		logic [9:0] py;
		logic       done;      // image complete after pixels
		logic       trunc;     // truncated error at end
	} job_t;
endpackage

@@ design/indexed_bmp_stream_decoder.sv @@
// Top level of the indexed BMP stream decoder.
// Depends on ibsd_pkg, ibsd_front, ibsd_queue and ibsd_back.
//
// Usage: feed one BMP file byte per transfer on the input channel
// (in_valid/in_ready, in_item), start_of_file marking byte 0 and end_of_file
// the last byte. Results leave on out_valid/out_ready as out_item: header
// accepted, palette colours, pixels with x,y (top row y = 0), image complete
// or an error; last_of_run closes the results of one byte.
// A byte's results pass through the job queue and then the output register;
// a byte whose only result is a truncation error first takes an empty step.
// The back end sends at most one result per cycle, holding while out_ready
// is low. A byte holds the back end one step per pixel slot (eight at 1 bpp,
// two at 4 bpp, one otherwise, one for a byte with no pixels), plus one
// step each for image complete and truncation. The two-entry job queue lets
// the parser, while it has room, take one byte per cycle as the back end emits.
// Reset clears the parser to the header phase; the header byte store is
// undefined until written. When the receiver stalls the output register
// holds, the queue fills and then in_ready falls.
module indexed_bmp_stream_decoder #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ibsd_pkg::in_item_t  in_item,
	input  logic                in_valid,
	output logic                in_ready,
	output ibsd_pkg::out_item_t out_item,
	output logic                out_valid,
	input  logic                out_ready
);
	ibsd_pkg::job_t fj, qj;
	logic fv, fr, qv, qr;

	ibsd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_ready(in_ready), .job(fj), .job_valid(fv), .job_ready(fr));

	ibsd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
		.rd_job(qj), .rd_valid(qv), .rd_ready(qr));

	ibsd_back u_back (
		.clk(clk), .arst_n(arst_n), .job(qj), .job_valid(qv), .job_ready(qr),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready));
endmodule

@@ design/ibsd_front.sv @@
// Front: parses bytes, keeps parser state, classifies each byte into a job.
// Depends on ibsd_pkg.
module ibsd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ibsd_pkg::in_item_t in_item,
	input  logic               in_valid,
	output logic               in_ready,
	output ibsd_pkg::job_t     job,
	output logic               job_valid,
	input  logic               job_ready
);
	ibsd_pkg::phase_t phase_q;
	logic [31:0] pos_q;
	logic [7:0]  hdr_q [ibsd_pkg::HEADER_BYTES];
	logic [31:0] info_q, offs_q;
	logic [10:0] width_q, height_q, row_q;
	logic        bup_q;
	logic [1:0]  depth_q, cphase_q;
	logic [8:0]  pents_q, pcnt_q;
	logic [15:0] bg_q;
	logic [11:0] rbc_q, pitch_q;

	logic fire;
	assign in_ready = job_ready;
	assign fire = in_valid && in_ready;
	assign job_valid = in_valid;

	// Effective state after start-of-file restart
	logic             sof;
	ibsd_pkg::phase_t ph;
	logic [31:0]      p, np;
	logic [7:0]       b;
	assign sof = in_item.start_of_file;
	assign b   = in_item.data_byte;
	assign ph  = sof ? ibsd_pkg::PH_HEADER : phase_q;
	assign p   = sof ? 32'd0 : pos_q;
	assign np  = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;

	// Header fields; none of them sits in the last header byte
	logic [31:0] w, h, colors0, comp, ihs, mag;
	logic [15:0] bpp;
	logic [8:0]  colors;
	logic        sig_ok, fmt_ok, pal_ok, size_ok;
	always_comb begin
		w    = {hdr_q[21], hdr_q[20], hdr_q[19], hdr_q[18]};
		h    = {hdr_q[25], hdr_q[24], hdr_q[23], hdr_q[22]};
		bpp  = {hdr_q[29], hdr_q[28]};
		comp = {hdr_q[33], hdr_q[32], hdr_q[31], hdr_q[30]};
		ihs  = {hdr_q[17], hdr_q[16], hdr_q[15], hdr_q[14]};
		colors0 = {hdr_q[49], hdr_q[48], hdr_q[47], hdr_q[46]};
		sig_ok = hdr_q[0] == 8'h42 && hdr_q[1] == 8'h4D;
		fmt_ok = ihs >= 32'd40 && w != 0 && !w[31] && h != 0 && comp == 0 &&
			(bpp == 16'd1 || bpp == 16'd4 || bpp == 16'd8);
		pal_ok = 1'b1;
		colors = '0;
		if (colors0 == 0) colors = 9'd1 << bpp[3:0];
		else if (colors0 > 32'd256) pal_ok = 1'b0;
		else colors = colors0[8:0];
		mag = h[31] ? (32'd0 - h) : h;
		size_ok = w <= 32'(MAX_WIDTH) && mag <= 32'(MAX_HEIGHT);
	end

	logic [11:0] pitch_new;
	always_comb begin
		logic [13:0] bits;
		bits = (bpp == 16'd1) ? {3'd0, w[10:0]} :
			(bpp == 16'd4) ? {1'b0, w[10:0], 2'd0} : {w[10:0], 3'd0};
		pitch_new = {1'b0, 11'((bits + 14'd31) >> 5)} << 2;
	end

	// Classify the byte and work out next state
	ibsd_pkg::job_t   j;
	ibsd_pkg::phase_t n_phase;
	logic [31:0] n_info, n_offs;
	logic [10:0] n_width, n_height, n_row;
	logic        n_bup;
	logic [1:0]  n_depth, n_cphase;
	logic [8:0]  n_pents, n_pcnt;
	logic [15:0] n_bg;
	logic [11:0] n_rbc, n_pitch;
	logic        err;
	always_comb begin
		j = '0;
		n_phase = ph;
		n_info = sof ? '0 : info_q;   n_offs = sof ? '0 : offs_q;
		n_width = sof ? '0 : width_q; n_height = sof ? '0 : height_q;
		n_row = sof ? '0 : row_q;     n_bup = sof ? 1'b0 : bup_q;
		n_depth = sof ? '0 : depth_q; n_cphase = sof ? '0 : cphase_q;
		n_pents = sof ? '0 : pents_q; n_pcnt = sof ? '0 : pcnt_q;
		n_bg = sof ? '0 : bg_q;       n_rbc = sof ? '0 : rbc_q;
		n_pitch = sof ? '0 : pitch_q;
		err = 1'b0;
		unique case (ph)
			ibsd_pkg::PH_HEADER: begin
				if (p == 32'd53) begin
					j.single = 1'b1;
					if (!sig_ok) begin
						j.res.kind = ibsd_pkg::KIND_ERROR;
						j.res.error_code = ibsd_pkg::ERR_SIGNATURE; err = 1'b1;
					end else begin
						n_info = ihs;
						n_offs = {hdr_q[13], hdr_q[12], hdr_q[11], hdr_q[10]};
						if (!fmt_ok) begin
							j.res.kind = ibsd_pkg::KIND_ERROR;
							j.res.error_code = ibsd_pkg::ERR_FORMAT; err = 1'b1;
						end else if (!pal_ok) begin
							j.res.kind = ibsd_pkg::KIND_ERROR;
							j.res.error_code = ibsd_pkg::ERR_PALETTE; err = 1'b1;
						end else if (!size_ok) begin
							j.res.kind = ibsd_pkg::KIND_ERROR;
							j.res.error_code = ibsd_pkg::ERR_TOO_LARGE; err = 1'b1;
						end else begin
							n_width = w[10:0]; n_height = mag[10:0];
							n_bup = !h[31];
							n_depth = (bpp == 16'd1) ? 2'd0 : (bpp == 16'd4) ? 2'd1 : 2'd2;
							n_pents = colors; n_pitch = pitch_new;
							j.res.kind = ibsd_pkg::KIND_HEADER;
							j.res.image_width = w[10:0];
							j.res.image_height = mag[10:0];
							j.res.color_count = colors;
							n_phase = ({1'b0, ihs} + 33'd14 == {1'b0, np}) ?
								ibsd_pkg::PH_PALETTE : ibsd_pkg::PH_SKIP_PAL;
						end
					end
				end
			end
			ibsd_pkg::PH_SKIP_PAL: begin
				if ({1'b0, info_q} + 33'd14 == {1'b0, np}) n_phase = ibsd_pkg::PH_PALETTE;
			end
			ibsd_pkg::PH_PALETTE: begin
				unique case (cphase_q)
					2'd0: n_bg[7:0] = b;
					2'd1: n_bg[15:8] = b;
					2'd2: begin
						j.single = 1'b1;
						j.res.kind = ibsd_pkg::KIND_COLOR;
						j.res.value = pcnt_q[7:0];
						j.res.red = b;
						j.res.green = bg_q[15:8];
						j.res.blue = bg_q[7:0];
					end
					default: begin
						n_pcnt = pcnt_q + 9'd1;
						if (n_pcnt >= pents_q) begin
							if (offs_q < np) begin
								j.single = 1'b1;
								j.res.kind = ibsd_pkg::KIND_ERROR;
								j.res.error_code = ibsd_pkg::ERR_OFFSET; err = 1'b1;
							end else if (offs_q == np) n_phase = ibsd_pkg::PH_PIXELS;
							else n_phase = ibsd_pkg::PH_SKIP_PIX;
						end
					end
				endcase
				n_cphase = cphase_q + 2'd1;
			end
			ibsd_pkg::PH_SKIP_PIX: begin
				if (offs_q == np) n_phase = ibsd_pkg::PH_PIXELS;
			end
			ibsd_pkg::PH_PIXELS: begin
				j.pix = 1'b1;
				j.pbyte = b;
				j.depth = depth_q;
				j.width = width_q;
				j.x0 = (depth_q == 2'd0) ? {rbc_q[7:0], 3'd0} :
					(depth_q == 2'd1) ? {rbc_q[9:0], 1'b0} : rbc_q[10:0];
				j.py = bup_q ? 10'(height_q - 11'd1 - row_q) : row_q[9:0];
				n_rbc = rbc_q + 12'd1;
				if (n_rbc >= pitch_q) begin
					n_rbc = '0;
					n_row = row_q + 11'd1;
					if (n_row >= height_q) begin
						j.done = 1'b1; n_phase = ibsd_pkg::PH_DONE;
					end
				end
			end
			default: ;
		endcase
		if (err) n_phase = ibsd_pkg::PH_ERROR;
		if (in_item.end_of_file && n_phase != ibsd_pkg::PH_DONE &&
			n_phase != ibsd_pkg::PH_ERROR) begin
			j.trunc = 1'b1; n_phase = ibsd_pkg::PH_ERROR;
		end
	end
	assign job = j;

	// Advance parser state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ibsd_pkg::PH_HEADER; pos_q <= '0; info_q <= '0; offs_q <= '0;
			width_q <= '0; height_q <= '0; row_q <= '0; bup_q <= 1'b0;
			depth_q <= '0; cphase_q <= '0; pents_q <= '0; pcnt_q <= '0;
			bg_q <= '0; rbc_q <= '0; pitch_q <= '0;
		end else if (fire) begin
			phase_q <= n_phase; pos_q <= np; info_q <= n_info; offs_q <= n_offs;
			width_q <= n_width; height_q <= n_height; row_q <= n_row; bup_q <= n_bup;
			depth_q <= n_depth; cphase_q <= n_cphase; pents_q <= n_pents;
			pcnt_q <= n_pcnt; bg_q <= n_bg; rbc_q <= n_rbc; pitch_q <= n_pitch;
		end
	end

	// Collect header bytes
	always_ff @(posedge clk) begin
		if (fire && ph == ibsd_pkg::PH_HEADER && p < 32'd54) hdr_q[p[5:0]] <= b;
	end
endmodule

@@ design/ibsd_queue.sv @@
// Two-entry job queue between front and back.
// Depends on ibsd_pkg and the shared assertion header.
`include "indexed_bmp_stream_decoder_defines.svh"
module ibsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ibsd_pkg::job_t wr_job,
	input  logic           wr_valid,
	output logic           wr_ready,
	output ibsd_pkg::job_t rd_job,
	output logic           rd_valid,
	input  logic           rd_ready
);
	ibsd_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;
	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	`IBSD_ASSERT_IMP(a_q_bound, 1'b1, cnt_q <= 2'd2)
	`IBSD_ASSERT_NXT(a_q_full, cnt_q == 2'd2 && !pop, cnt_q == 2'd2)
	`IBSD_ASSERT_NXT(a_q_empty, cnt_q == 2'd0 && !push, cnt_q == 2'd0)
endmodule

@@ design/ibsd_back.sv @@
// Back: expands jobs to items in an output register, one per cycle when not stalled.
// Depends on ibsd_pkg and the shared assertion header.
`include "indexed_bmp_stream_decoder_defines.svh"
module ibsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ibsd_pkg::job_t      job,
	input  logic                job_valid,
	output logic                job_ready,
	output ibsd_pkg::out_item_t out_item,
	output logic                out_valid,
	input  logic                out_ready
);
	// Step through a job: pixel k, then done, then truncated
	typedef enum logic [2:0] {
		TAIL_BODY  = 3'b001,
		TAIL_DONE  = 3'b010,
		TAIL_TRUNC = 3'b100
	} tail_t;

	logic [3:0] k_q;
	tail_t      tail_q;   // body: pixels or single result, then done, then trunc
	logic       slot_free;
	logic [3:0] per;
	logic [10:0] x;
	logic [7:0] idx;
	logic       have;
	logic       any_later;
	ibsd_pkg::out_item_t r;
	logic       step_end;

	assign slot_free = !out_valid || out_ready;

	always_comb begin
		logic pix_left;
		per = (job.depth == 2'd0) ? 4'd8 : (job.depth == 2'd1) ? 4'd2 : 4'd1;
		x = job.x0 + {7'd0, k_q};
		unique case (job.depth)
			2'd0: idx = {7'd0, job.pbyte[3'd7 - k_q[2:0]]};
			2'd1: idx = k_q[0] ? {4'd0, job.pbyte[3:0]} : {4'd0, job.pbyte[7:4]};
			default: idx = job.pbyte;
		endcase
		r = '0;
		have = 1'b0;
		step_end = 1'b0;
		pix_left = 1'b0;
		if (tail_q == TAIL_BODY) begin
			if (job.single) begin
				r = job.res; have = 1'b1;
			end else if (job.pix) begin
				have = x < job.width;
				r.kind = ibsd_pkg::KIND_PIXEL;
				r.value = idx;
				r.pixel_x = x[9:0];
				r.pixel_y = job.py;
				pix_left = k_q + 4'd1 < per;
			end
			any_later = pix_left || job.done || job.trunc;
			step_end = !pix_left;
		end else if (tail_q == TAIL_DONE) begin
			r.kind = ibsd_pkg::KIND_DONE; have = 1'b1;
			any_later = job.trunc;
			step_end = 1'b1;
		end else begin
			r.kind = ibsd_pkg::KIND_ERROR;
			r.error_code = ibsd_pkg::ERR_TRUNCATED; have = 1'b1;
			any_later = 1'b0;
			step_end = 1'b1;
		end
		// last if no later result in this job can appear
		if (tail_q == TAIL_BODY && job.pix && pix_left) begin
			// later pixels exist only if their x is in range; x grows so check next
			any_later = (x + 11'd1 < job.width) || job.done || job.trunc;
		end
		r.last_of_run = !any_later;
	end

	logic advance;
	logic job_fin;
	assign advance = job_valid && slot_free;
	assign job_fin = advance && (tail_q == TAIL_TRUNC ||
		(tail_q == TAIL_DONE && !job.trunc) ||
		(tail_q == TAIL_BODY && step_end && !job.done && !job.trunc));
	assign job_ready = job_fin;

	// Walk the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0; tail_q <= TAIL_BODY;
		end else if (advance) begin
			if (job_fin) begin
				k_q <= '0; tail_q <= TAIL_BODY;
			end else if (tail_q == TAIL_BODY && !step_end) begin
				k_q <= k_q + 4'd1;
			end else if (tail_q == TAIL_BODY && job.done) begin
				tail_q <= TAIL_DONE;
			end else begin
				tail_q <= TAIL_TRUNC;
			end
		end
	end

	// Output register
	ibsd_pkg::out_item_t out_q;
	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (slot_free) ov_q <= advance && have;
	end
	always_ff @(posedge clk) begin
		if (slot_free && advance && have) out_q <= r;
	end
	assign out_item = out_q;
	assign out_valid = ov_q;

	`IBSD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_item))
	`IBSD_ASSERT_IMP(a_k_range, 1'b1, k_q < 4'd8)
	`IBSD_ASSERT_IMP(a_tail, job_ready, job_valid)
endmodule

@@ tb/indexed_bmp_stream_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of indexed_bmp_stream_decoder: BMP byte streams in,
// decoded header, colour, pixel, error and completion transfers checked out.
// Depends on ibsd_pkg and the decoder RTL.
module indexed_bmp_stream_decoder_test;
	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef enum logic [2:0] {
		PH_HEADER, PH_SKIP_PAL, PH_PALETTE, PH_SKIP_PIX, PH_PIXELS, PH_DONE, PH_ERROR
	} phase_t;

	logic                clk;
	logic                arst_n;
	ibsd_pkg::in_item_t  in_item;
	logic                in_valid;
	logic                in_ready;
	ibsd_pkg::out_item_t out_item;
	logic                out_valid;
	logic                out_ready;

	indexed_bmp_stream_decoder #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
	);

	ibsd_pkg::in_item_t  byte_q[$];
	ibsd_pkg::out_item_t decoded_q[$];
	ibsd_pkg::out_item_t step_q[$];
	int        bytes_total;
	int        bytes_taken;
	int        mismatches;
	int        quiet_cycles;
	int        hold_left;
	bit        hold_done;
	bit        in_taken;

	// decoder state as the predictor sees it
	logic [7:0]  hdr_bytes [54];
	phase_t      phase;
	logic [31:0] pos, info_size, pix_offset;
	logic [10:0] img_w, img_h, row_idx;
	bit          flip;
	int          bpp_in_use;
	logic [8:0]  pal_total, pal_idx;
	logic [1:0]  col_phase;
	logic [15:0] held_bg;
	logic [11:0] row_byte, pitch;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] hdr_word(int at);
		return {hdr_bytes[at + 3], hdr_bytes[at + 2], hdr_bytes[at + 1], hdr_bytes[at]};
	endfunction

	function automatic ibsd_pkg::out_item_t blank_result(logic [2:0] k);
		ibsd_pkg::out_item_t o;
		o = '0;
		o.kind = k;
		return o;
	endfunction

	function automatic void clear_parser();
		phase = PH_HEADER;
		pos = 0;
		info_size = 0;
		pix_offset = 0;
		img_w = 0;
		img_h = 0;
		flip = 0;
		bpp_in_use = 1;
		pal_total = 0;
		pal_idx = 0;
		col_phase = 0;
		held_bg = 0;
		row_idx = 0;
		row_byte = 0;
		pitch = 0;
	endfunction

	function automatic void raise_error(logic [2:0] code);
		ibsd_pkg::out_item_t o;
		o = blank_result(ibsd_pkg::KIND_ERROR);
		o.error_code = code;
		step_q.push_back(o);
		phase = PH_ERROR;
	endfunction

	function automatic void judge_header();
		logic [31:0] w, h, colors, mag;
		logic [15:0] bpp;
		ibsd_pkg::out_item_t o;
		w = hdr_word(18);
		h = hdr_word(22);
		colors = hdr_word(46);
		bpp = {hdr_bytes[29], hdr_bytes[28]};
		if (hdr_bytes[0] != "B" || hdr_bytes[1] != "M") begin
			raise_error(ibsd_pkg::ERR_SIGNATURE);
			return;
		end
		info_size = hdr_word(14);
		pix_offset = hdr_word(10);
		if (info_size < 40 || w == 0 || w[31] || h == 0 || hdr_word(30) != 0 ||
				(bpp != 1 && bpp != 4 && bpp != 8)) begin
			raise_error(ibsd_pkg::ERR_FORMAT);
			return;
		end
		if (colors == 0)
			colors = 32'd1 << bpp;
		if (colors > 256) begin
			raise_error(ibsd_pkg::ERR_PALETTE);
			return;
		end
		mag = h[31] ? (32'd0 - h) : h;
		if (w > MAX_W || mag > MAX_H) begin
			raise_error(ibsd_pkg::ERR_TOO_LARGE);
			return;
		end
		img_w = w[10:0];
		img_h = mag[10:0];
		flip = !h[31];
		bpp_in_use = bpp;
		pal_total = colors[8:0];
		pitch = ((w * bpp + 31) / 32) * 4;
		o = blank_result(ibsd_pkg::KIND_HEADER);
		o.image_width = w[10:0];
		o.image_height = mag[10:0];
		o.color_count = colors[8:0];
		step_q.push_back(o);
		phase = ({32'd0, info_size} + 64'd14 == {32'd0, pos}) ? PH_PALETTE : PH_SKIP_PAL;
	endfunction

	function automatic void unpack_pixels(logic [7:0] b);
		int per, x;
		ibsd_pkg::out_item_t o;
		per = 8 / bpp_in_use;
		for (int k = 0; k < per; k++) begin
			x = row_byte * per + k;
			if (x < img_w) begin
				o = blank_result(ibsd_pkg::KIND_PIXEL);
				o.value = (b >> (8 - bpp_in_use * (k + 1))) & ((1 << bpp_in_use) - 1);
				o.pixel_x = x;
				o.pixel_y = flip ? (img_h - 1 - row_idx) : row_idx;
				step_q.push_back(o);
			end
		end
		row_byte++;
		if (row_byte >= pitch) begin
			row_byte = 0;
			row_idx++;
			if (row_idx >= img_h) begin
				step_q.push_back(blank_result(ibsd_pkg::KIND_DONE));
				phase = PH_DONE;
			end
		end
	endfunction

	// work out the results of one transferred byte
	function automatic void decode_byte(ibsd_pkg::in_item_t it);
		logic [31:0] p;
		ibsd_pkg::out_item_t o;
		step_q.delete();
		if (it.start_of_file)
			clear_parser();
		p = pos;
		if (pos != 32'hFFFF_FFFF)
			pos++;
		case (phase)
			PH_HEADER: begin
				if (p < 54)
					hdr_bytes[p] = it.data_byte;
				if (p == 53)
					judge_header();
			end
			PH_SKIP_PAL: begin
				if ({32'd0, info_size} + 64'd14 == {32'd0, pos})
					phase = PH_PALETTE;
			end
			PH_PALETTE: begin
				case (col_phase)
					2'd0: held_bg[7:0] = it.data_byte;
					2'd1: held_bg[15:8] = it.data_byte;
					2'd2: begin
						o = blank_result(ibsd_pkg::KIND_COLOR);
						o.value = pal_idx[7:0];
						o.red = it.data_byte;
						o.green = held_bg[15:8];
						o.blue = held_bg[7:0];
						step_q.push_back(o);
					end
					default: begin
						pal_idx++;
						if (pal_idx >= pal_total) begin
							if (pix_offset < pos)
								raise_error(ibsd_pkg::ERR_OFFSET);
							else if (pix_offset == pos)
								phase = PH_PIXELS;
							else
								phase = PH_SKIP_PIX;
						end
					end
				endcase
				col_phase++;
			end
			PH_SKIP_PIX: begin
				if (pix_offset == pos)
					phase = PH_PIXELS;
			end
			PH_PIXELS: unpack_pixels(it.data_byte);
			default: ;
		endcase
		if (it.end_of_file && phase != PH_DONE && phase != PH_ERROR)
			raise_error(ibsd_pkg::ERR_TRUNCATED);
		foreach (step_q[k]) begin
			step_q[k].last_of_run = (k == step_q.size() - 1);
			decoded_q.push_back(step_q[k]);
		end
	endfunction

	function automatic void put_le32(ref logic [7:0] f[$], input int at, input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			f[at + i] = v[8 * i +: 8];
	endfunction

	// queue one BMP file; cut keeps only the leading bytes when nonzero
	task automatic queue_file(input int bpp, input int unsigned w, input int h,
			input int unsigned colors, input int info, input int gap, input int cut,
			input bit sof, input bit eof_last, input int corrupt_at = -1,
			input logic [7:0] corrupt_val = 0, input bit bad_sig = 0,
			input int unsigned compression = 0);
		logic [7:0] f[$];
		int ncol, mag, row_len, n;
		ibsd_pkg::in_item_t it;
		for (int i = 0; i < 54; i++)
			f.push_back($urandom_range(0, 255));
		ncol = (colors == 0) ? (1 << bpp) : colors;
		if (ncol > 300)
			ncol = 300;
		mag = (h < 0) ? -h : h;
		row_len = (w <= MAX_W) ? ((w * bpp + 31) / 32) * 4 : 0;
		f[0] = bad_sig ? "b" : "B";
		f[1] = "M";
		put_le32(f, 10, 14 + info + 4 * ncol + gap);
		put_le32(f, 14, info);
		put_le32(f, 18, w);
		put_le32(f, 22, h);
		f[28] = bpp;
		f[29] = 0;
		put_le32(f, 30, compression);
		put_le32(f, 46, colors);
		for (int i = 0; i < info - 40 + 4 * ncol; i++)
			f.push_back($urandom_range(0, 255));
		for (int i = 0; i < gap; i++)
			f.push_back($urandom_range(0, 255));
		if (mag > 0 && mag <= MAX_H)
			for (int i = 0; i < row_len * mag; i++)
				f.push_back($urandom_range(0, 255));
		if (corrupt_at >= 0)
			f[corrupt_at] = corrupt_val;
		n = (cut > 0 && cut < f.size()) ? cut : f.size();
		for (int i = 0; i < n; i++) begin
			it.data_byte = f[i];
			it.start_of_file = sof && (i == 0);
			it.end_of_file = eof_last && (i == n - 1);
			byte_q.push_back(it);
		end
	endtask

	task automatic queue_noise(input int n);
		ibsd_pkg::in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.data_byte = $urandom_range(0, 255);
			it.start_of_file = 1'b0;
			it.end_of_file = $urandom_range(0, 1);
			byte_q.push_back(it);
		end
	endtask

	task automatic build_stimulus();
		int bpp, w, h, colors, gap, cut, corrupt;
		// directed: well-formed files of each depth and orientation
		queue_file(1, 9, 2, 0, 40, 0, 0, 0, 1);
		queue_noise(3);
		queue_file(4, 5, -3, 2, 44, 7, 0, 1, 1);
		queue_file(8, 2, -1, 1, 52, 0, 0, 1, 1);
		// directed: header rejections
		queue_file(2, 4, 1, 0, 40, 0, 54, 1, 0);
		queue_file(8, 4, int'(32'h8000_0000), 1, 40, 0, 54, 1, 0);
		// directed: offset behind the palette, restart mid-header, early end
		queue_file(4, 3, 2, 2, 40, -4, 62, 1, 1);
		queue_file(1, 3, 2, 0, 40, 0, 30, 1, 0);
		queue_file(1, 3, 2, 0, 40, 0, 1, 1, 1);
		// random files, mostly well formed
		while (byte_q.size() < 440) begin
			case ($urandom_range(0, 2))
				0: bpp = 1;
				1: bpp = 4;
				default: bpp = 8;
			endcase
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 3);
			if ($urandom_range(0, 2) == 0)
				h = -h;
			colors = (bpp == 8) ? $urandom_range(1, 6) : $urandom_range(0, 2);
			gap = ($urandom_range(0, 11) == 0) ? -4 : $urandom_range(0, 5);
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : 0;
			corrupt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 53) : -1;
			queue_file(bpp, w, h, colors, $urandom_range(40, 46), gap, cut, 1, 1,
				corrupt, $urandom_range(0, 255));
			if ($urandom_range(0, 5) == 0)
				queue_noise($urandom_range(1, 4));
		end
		bytes_total = byte_q.size();
	endtask

	function automatic int idle_percent(bit sender);
		if (bytes_taken < bytes_total / 3)
			return sender ? 21 : 49;
		if (bytes_taken < 2 * bytes_total / 3)
			return sender ? 49 : 21;
		return 0;
	endfunction

	// sender: offer the next byte, hold it until the transfer
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_percent(1)) begin
				in_item <= byte_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && bytes_taken >= 150) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= idle_percent(0));
			end
		end
	end

	task automatic check_field(string name, logic [10:0] exp_v, logic [10:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// predict on input transfers, check output transfers, watch for hangs
	always @(posedge clk) begin
		ibsd_pkg::out_item_t e;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				decode_byte(in_item);
				bytes_taken++;
			end
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result transfer, kind %0d", out_item.kind);
					mismatches++;
				end else begin
					e = decoded_q.pop_front();
					check_field("kind", e.kind, out_item.kind);
					check_field("value", e.value, out_item.value);
					check_field("red", e.red, out_item.red);
					check_field("green", e.green, out_item.green);
					check_field("blue", e.blue, out_item.blue);
					check_field("pixel_x", e.pixel_x, out_item.pixel_x);
					check_field("pixel_y", e.pixel_y, out_item.pixel_y);
					check_field("image_width", e.image_width, out_item.image_width);
					check_field("image_height", e.image_height, out_item.image_height);
					check_field("color_count", e.color_count, out_item.color_count);
					check_field("error_code", e.error_code, out_item.error_code);
					check_field("last_of_run", e.last_of_run, out_item.last_of_run);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("indexed_bmp_stream_decoder regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		in_taken = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		bytes_taken = 0;
		mismatches = 0;
		quiet_cycles = 0;
		foreach (hdr_bytes[i])
			hdr_bytes[i] = '0;
		clear_parser();
		build_stimulus();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// drain input, then outstanding results, then settle
		do @(posedge clk); while (byte_q.size() > 0 || in_valid);
		do @(posedge clk); while (decoded_q.size() > 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("indexed_bmp_stream_decoder regression: pass");
		end else begin
			$display("indexed_bmp_stream_decoder regression: fail");
		end
		$finish;
	end
endmodule

@@ indexed_bmp_stream_decoder.f @@
+incdir+design
design/ibsd_pkg.sv
design/ibsd_front.sv
design/ibsd_queue.sv
design/ibsd_back.sv
design/indexed_bmp_stream_decoder.sv
tb/indexed_bmp_stream_decoder_test.sv
